/* rtl/ldif_a2p_pkg.sv */
// ----------------------------------------------------------------------------
// ldif_a2p_pkg
// Shared constants, types and text helpers for the LDIF attribute to PEM
// stream converter.
// ----------------------------------------------------------------------------
package ldif_a2p_pkg;

    localparam int MAX_ATTR_CHARS  = 40;
    localparam int MAX_LABEL_CHARS = 16;
    localparam int LINE_WIDTH      = 64;

    // configuration register map
    localparam int ATTR_REGS        = MAX_ATTR_CHARS / 8;
    localparam int LABEL_REGS       = MAX_LABEL_CHARS / 8;
    localparam int NUM_REGS         = ATTR_REGS + LABEL_REGS + 1;
    localparam int REG_NAME_LENGTHS = NUM_REGS - 1;
    localparam int REG_IDX_W        = $clog2(NUM_REGS);
    localparam int ATTR_SEL_W       = $clog2(ATTR_REGS);
    localparam int LABEL_SEL_W      = $clog2(LABEL_REGS);
    localparam int CFG_DATA_W       = 64;
    localparam int LEN_REG_W        = 13;
    localparam int ATTR_LEN_FIELD_W = 6;
    localparam int LABEL_LEN_LSB    = 8;
    localparam int LABEL_LEN_FIELD_W = 5;

    localparam int ATTR_POS_W   = $clog2(MAX_ATTR_CHARS + 1);
    localparam int LABEL_LEN_W  = $clog2(MAX_LABEL_CHARS + 1);
    localparam int LABEL_IDX_W  = $clog2(MAX_LABEL_CHARS);
    localparam int COL_W        = $clog2(LINE_WIDTH);

    // text pieces of the header and footer lines
    localparam int BEGIN_LEN     = 11;
    localparam int END_LEN       = 9;
    localparam int TAIL_LEN      = 6;
    localparam int PREFIX_IDX_W  = $clog2(BEGIN_LEN);
    localparam int TAIL_IDX_W    = $clog2(TAIL_LEN);
    localparam int MAX_RESULTS   = BEGIN_LEN + MAX_LABEL_CHARS + TAIL_LEN;
    localparam int IDX_W         = $clog2(MAX_RESULTS);

    localparam int TDATA_W = 16;

    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // reported phase codes
    localparam logic [2:0] PH_SEARCH   = 3'd0;
    localparam logic [2:0] PH_DATA     = 3'd1;
    localparam logic [2:0] PH_LINE_END = 3'd2;
    localparam logic [2:0] PH_FOOTER   = 3'd3;
    localparam logic [2:0] PH_DONE     = 3'd4;
    localparam logic [2:0] PH_BAD      = 3'd5;

    typedef enum logic [2:0] {
        KIND_EMPTY,
        KIND_BYTE,
        KIND_BYTE_NL,
        KIND_HEADER,
        KIND_FOOTER
    } t_kind;

    // what one accepted byte asks the output side to send
    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
        logic [2:0] phase;
        logic       nl;
    } t_job;

    typedef struct packed {
        logic [MAX_ATTR_CHARS-1:0][7:0]  attr;
        logic [MAX_LABEL_CHARS-1:0][7:0] label;
        logic [ATTR_POS_W-1:0]           attr_len;
        logic [LABEL_LEN_W-1:0]          label_len;
    } t_cfg;

    function automatic logic [7:0] upcase(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h61 && c <= 8'h7A) begin
            r = c - 8'h20;
        end
        return r;
    endfunction

    // "-----BEGIN "
    function automatic logic [7:0] begin_char(input logic [PREFIX_IDX_W-1:0] i);
        logic [7:0] r;
        case (i)
            4'd5:    r = 8'h42;
            4'd6:    r = 8'h45;
            4'd7:    r = 8'h47;
            4'd8:    r = 8'h49;
            4'd9:    r = 8'h4E;
            4'd10:   r = 8'h20;
            default: r = 8'h2D;
        endcase
        return r;
    endfunction

    // "-----END "
    function automatic logic [7:0] end_char(input logic [PREFIX_IDX_W-1:0] i);
        logic [7:0] r;
        case (i)
            4'd5:    r = 8'h45;
            4'd6:    r = 8'h4E;
            4'd7:    r = 8'h44;
            4'd8:    r = 8'h20;
            default: r = 8'h2D;
        endcase
        return r;
    endfunction

    // "-----\n"
    function automatic logic [7:0] tail_char(input logic [TAIL_IDX_W-1:0] i);
        logic [7:0] r;
        case (i)
            3'd5:    r = CH_NL;
            default: r = 8'h2D;
        endcase
        return r;
    endfunction

endpackage

/* rtl/ldif_a2p_cfg_regs.sv */
// ----------------------------------------------------------------------------
// ldif_a2p_cfg_regs
// Configuration registers: attribute name, PEM label and their lengths,
// with the lengths saturated to the supported ranges.
// ----------------------------------------------------------------------------
module ldif_a2p_cfg_regs (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [ldif_a2p_pkg::REG_IDX_W-1:0]    i_cfg_idx,
    input  logic [ldif_a2p_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    output ldif_a2p_pkg::t_cfg                    o_cfg
);

    logic [ldif_a2p_pkg::ATTR_REGS-1:0][ldif_a2p_pkg::CFG_DATA_W-1:0]  r_attr;
    logic [ldif_a2p_pkg::LABEL_REGS-1:0][ldif_a2p_pkg::CFG_DATA_W-1:0] r_label;
    logic [ldif_a2p_pkg::LEN_REG_W-1:0]                                r_len;

    logic [ldif_a2p_pkg::REG_IDX_W-1:0]         label_off;
    logic [ldif_a2p_pkg::ATTR_LEN_FIELD_W-1:0]  attr_raw;
    logic [ldif_a2p_pkg::LABEL_LEN_FIELD_W-1:0] label_raw;

    assign label_off = i_cfg_idx - ldif_a2p_pkg::REG_IDX_W'(ldif_a2p_pkg::ATTR_REGS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr  <= '0;
            r_label <= '0;
            r_len   <= ldif_a2p_pkg::LEN_REG_W'(1);
        end else if (i_cfg_we) begin
            if (i_cfg_idx < ldif_a2p_pkg::REG_IDX_W'(ldif_a2p_pkg::ATTR_REGS)) begin
                r_attr[i_cfg_idx[ldif_a2p_pkg::ATTR_SEL_W-1:0]] <= i_cfg_wdata;
            end else if (i_cfg_idx <
                         ldif_a2p_pkg::REG_IDX_W'(ldif_a2p_pkg::REG_NAME_LENGTHS)) begin
                r_label[label_off[ldif_a2p_pkg::LABEL_SEL_W-1:0]] <= i_cfg_wdata;
            end else if (i_cfg_idx ==
                         ldif_a2p_pkg::REG_IDX_W'(ldif_a2p_pkg::REG_NAME_LENGTHS)) begin
                r_len <= i_cfg_wdata[ldif_a2p_pkg::LEN_REG_W-1:0];
            end
        end
    end

    assign attr_raw  = r_len[ldif_a2p_pkg::ATTR_LEN_FIELD_W-1:0];
    assign label_raw = r_len[ldif_a2p_pkg::LABEL_LEN_LSB +: ldif_a2p_pkg::LABEL_LEN_FIELD_W];

    always_comb begin
        o_cfg.attr  = r_attr;
        o_cfg.label = r_label;
        if (attr_raw == '0) begin
            o_cfg.attr_len = ldif_a2p_pkg::ATTR_POS_W'(1);
        end else if (attr_raw >
                     ldif_a2p_pkg::ATTR_LEN_FIELD_W'(ldif_a2p_pkg::MAX_ATTR_CHARS)) begin
            o_cfg.attr_len = ldif_a2p_pkg::ATTR_POS_W'(ldif_a2p_pkg::MAX_ATTR_CHARS);
        end else begin
            o_cfg.attr_len = ldif_a2p_pkg::ATTR_POS_W'(attr_raw);
        end
        if (label_raw > ldif_a2p_pkg::LABEL_LEN_FIELD_W'(ldif_a2p_pkg::MAX_LABEL_CHARS)) begin
            o_cfg.label_len = ldif_a2p_pkg::LABEL_LEN_W'(ldif_a2p_pkg::MAX_LABEL_CHARS);
        end else begin
            o_cfg.label_len = ldif_a2p_pkg::LABEL_LEN_W'(label_raw);
        end
    end

endmodule

/* rtl/ldif_a2p_parser.sv */
// ----------------------------------------------------------------------------
// ldif_a2p_parser
// Conversion state machine: attribute search, data copy with line wrap,
// continuation check and footer trigger. Produces one output job per byte.
// ----------------------------------------------------------------------------
module ldif_a2p_parser (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic [7:0]           i_byte,
    input  ldif_a2p_pkg::t_cfg   i_cfg,
    output ldif_a2p_pkg::t_job   o_job
);

    typedef enum logic [4:0] {
        ST_SEARCH   = 5'b00001,
        ST_DATA     = 5'b00010,
        ST_LINE_END = 5'b00100,
        ST_FOOTER   = 5'b01000,
        ST_DONE     = 5'b10000
    } t_phase;

    t_phase                              r_phase, n_phase;
    logic [ldif_a2p_pkg::ATTR_POS_W-1:0] r_match_pos, n_match_pos;
    logic [ldif_a2p_pkg::COL_W-1:0]      r_col, n_col;

    logic [7:0]                          attr_ch;
    logic                                hit;
    logic [ldif_a2p_pkg::ATTR_POS_W:0]   pos_inc;

    always_comb begin
        if (r_match_pos < ldif_a2p_pkg::ATTR_POS_W'(ldif_a2p_pkg::MAX_ATTR_CHARS)) begin
            attr_ch = i_cfg.attr[r_match_pos];
        end else begin
            attr_ch = 8'h00;
        end
        // a length lowered mid-match lets the next byte complete it
        hit = (r_match_pos >= i_cfg.attr_len) ||
              (ldif_a2p_pkg::upcase(i_byte) == ldif_a2p_pkg::upcase(attr_ch));
        pos_inc = {1'b0, r_match_pos} + 1'b1;
    end

    always_comb begin
        n_phase     = r_phase;
        n_match_pos = r_match_pos;
        n_col       = r_col;
        o_job.kind  = ldif_a2p_pkg::KIND_EMPTY;
        o_job.data  = i_byte;
        o_job.phase = ldif_a2p_pkg::PH_DONE;
        o_job.nl    = 1'b0;
        case (r_phase)
            ST_SEARCH: begin
                o_job.phase = ldif_a2p_pkg::PH_SEARCH;
                if (hit && pos_inc >= {1'b0, i_cfg.attr_len}) begin
                    n_match_pos = '0;
                    n_phase     = ST_DATA;
                    o_job.kind  = ldif_a2p_pkg::KIND_HEADER;
                    o_job.phase = ldif_a2p_pkg::PH_DATA;
                end else if (hit) begin
                    n_match_pos = pos_inc[ldif_a2p_pkg::ATTR_POS_W-1:0];
                end else begin
                    n_match_pos = '0;
                end
            end
            ST_DATA: begin
                if (i_byte == ldif_a2p_pkg::CH_NL) begin
                    n_phase     = ST_LINE_END;
                    o_job.phase = ldif_a2p_pkg::PH_LINE_END;
                end else begin
                    o_job.phase = ldif_a2p_pkg::PH_DATA;
                    if (r_col == ldif_a2p_pkg::COL_W'(ldif_a2p_pkg::LINE_WIDTH - 1)) begin
                        n_col      = '0;
                        o_job.kind = ldif_a2p_pkg::KIND_BYTE_NL;
                    end else begin
                        n_col      = r_col + 1'b1;
                        o_job.kind = ldif_a2p_pkg::KIND_BYTE;
                    end
                end
            end
            ST_LINE_END: begin
                if (i_byte == ldif_a2p_pkg::CH_SPACE) begin
                    n_phase     = ST_DATA;
                    o_job.phase = ldif_a2p_pkg::PH_DATA;
                end else if (i_byte == ldif_a2p_pkg::CH_NL) begin
                    n_phase     = ST_FOOTER;
                    o_job.phase = ldif_a2p_pkg::PH_FOOTER;
                end else begin
                    o_job.phase = ldif_a2p_pkg::PH_BAD;
                end
            end
            ST_FOOTER: begin
                n_col       = '0;
                n_phase     = ST_DONE;
                o_job.kind  = ldif_a2p_pkg::KIND_FOOTER;
                o_job.nl    = (r_col != '0);
                o_job.phase = ldif_a2p_pkg::PH_DONE;
            end
            default: begin
                n_phase = ST_DONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= ST_SEARCH;
            r_match_pos <= '0;
            r_col       <= '0;
        end else if (i_accept) begin
            r_phase     <= n_phase;
            r_match_pos <= n_match_pos;
            r_col       <= n_col;
        end
    end

endmodule

/* rtl/ldif_a2p_emitter.sv */
// ----------------------------------------------------------------------------
// ldif_a2p_emitter
// Holds one output job and plays it out one byte per cycle while m_tready
// allows: single, wrapped or empty results, and header and footer bursts.
// ----------------------------------------------------------------------------
module ldif_a2p_emitter (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_accept,
    input  ldif_a2p_pkg::t_job                   i_job,
    input  ldif_a2p_pkg::t_cfg                   i_cfg,
    output logic                                 o_ready,
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    output logic [ldif_a2p_pkg::TDATA_W-1:0]     o_m_tdata,
    output logic                                 o_m_tuser,
    output logic                                 o_m_tlast
);

    logic                           r_job_valid;
    ldif_a2p_pkg::t_job             r_job;
    logic [ldif_a2p_pkg::IDX_W-1:0] r_idx;

    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic [2:0] r_out_phase;
    logic       r_out_user;
    logic       r_out_last;

    logic                           out_free;
    logic                           step;
    logic                           job_done;
    logic [ldif_a2p_pkg::IDX_W-1:0] pos;
    logic [ldif_a2p_pkg::IDX_W-1:0] q;
    logic [ldif_a2p_pkg::IDX_W-1:0] t;
    logic [ldif_a2p_pkg::IDX_W-1:0] prefix_len;
    logic [ldif_a2p_pkg::IDX_W-1:0] last_pos;
    logic [7:0]                     text_ch;
    logic [7:0]                     res_byte;
    logic                           res_valid;
    logic                           res_last;

    // position inside the text line, after the optional leading newline
    always_comb begin
        if (r_job.kind == ldif_a2p_pkg::KIND_HEADER) begin
            prefix_len = ldif_a2p_pkg::IDX_W'(ldif_a2p_pkg::BEGIN_LEN);
        end else begin
            prefix_len = ldif_a2p_pkg::IDX_W'(ldif_a2p_pkg::END_LEN);
        end
        pos      = r_idx - ldif_a2p_pkg::IDX_W'(r_job.nl);
        q        = pos - prefix_len;
        t        = q - ldif_a2p_pkg::IDX_W'(i_cfg.label_len);
        last_pos = prefix_len + ldif_a2p_pkg::IDX_W'(i_cfg.label_len) +
                   ldif_a2p_pkg::IDX_W'(ldif_a2p_pkg::TAIL_LEN - 1);
        if (pos < prefix_len) begin
            if (r_job.kind == ldif_a2p_pkg::KIND_HEADER) begin
                text_ch = ldif_a2p_pkg::begin_char(pos[ldif_a2p_pkg::PREFIX_IDX_W-1:0]);
            end else begin
                text_ch = ldif_a2p_pkg::end_char(pos[ldif_a2p_pkg::PREFIX_IDX_W-1:0]);
            end
        end else if (q < ldif_a2p_pkg::IDX_W'(i_cfg.label_len)) begin
            text_ch = i_cfg.label[q[ldif_a2p_pkg::LABEL_IDX_W-1:0]];
        end else begin
            text_ch = ldif_a2p_pkg::tail_char(t[ldif_a2p_pkg::TAIL_IDX_W-1:0]);
        end
    end

    always_comb begin
        res_byte  = 8'h00;
        res_valid = 1'b1;
        res_last  = 1'b1;
        case (r_job.kind)
            ldif_a2p_pkg::KIND_BYTE: begin
                res_byte = r_job.data;
            end
            ldif_a2p_pkg::KIND_BYTE_NL: begin
                res_byte = (r_idx == '0) ? r_job.data : ldif_a2p_pkg::CH_NL;
                res_last = (r_idx != '0);
            end
            ldif_a2p_pkg::KIND_HEADER, ldif_a2p_pkg::KIND_FOOTER: begin
                if (r_job.nl && r_idx == '0) begin
                    res_byte = ldif_a2p_pkg::CH_NL;
                    res_last = 1'b0;
                end else begin
                    res_byte = text_ch;
                    res_last = (pos == last_pos);
                end
            end
            default: begin
                res_valid = 1'b0;
            end
        endcase
    end

    assign out_free = !r_out_valid || i_m_tready;
    assign step     = r_job_valid && out_free;
    assign job_done = step && res_last;
    assign o_ready  = !r_job_valid || job_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_valid <= 1'b0;
            r_idx       <= '0;
        end else if (i_accept) begin
            r_job_valid <= 1'b1;
            r_idx       <= '0;
        end else if (job_done) begin
            r_job_valid <= 1'b0;
        end else if (step) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_job <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_byte  <= res_byte;
            r_out_phase <= r_job.phase;
            r_out_user  <= res_valid;
            r_out_last  <= res_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(ldif_a2p_pkg::TDATA_W - 11){1'b0}}, r_out_phase, r_out_byte};
    assign o_m_tuser  = r_out_user;
    assign o_m_tlast  = r_out_last;

    // an empty result is always the only one of its transaction group
    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_user |-> r_out_last)
        else $error("empty result without last");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_job_valid |-> r_idx < ldif_a2p_pkg::IDX_W'(ldif_a2p_pkg::MAX_RESULTS))
        else $error("burst index past longest burst");

    a_burst_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_job_valid && !job_done |=> r_job_valid)
        else $error("job dropped before its last byte");

endmodule

/* rtl/ldif_attribute_to_pem_stream.sv */
// ----------------------------------------------------------------------------
// ldif_attribute_to_pem_stream
// Finds a configured attribute in an LDIF byte stream and rewrites its value
// as PEM text with header, 64-column wrapping and footer.
//
// channel   dir  width  contents
// s_*       in   8      tdata[7:0] LDIF byte
// m_*       out  16     tdata[7:0] out_byte, [10:8] phase; tuser byte_valid;
//                       tlast last result of the input byte
// cfg       in   64     i_cfg_we, i_cfg_idx (register 0..7), i_cfg_wdata
//
// an input byte gives one result; a wrapped byte gives 2, the header
// 17 + label length, the footer 15 or 16 + label length results; the
// output register drains one byte per cycle while m_tready does not hold it.
// an accepted byte is registered as a job, then its results in the output register.
// synchronous active-low reset clears state and the name registers, lengths to 1.
// s_tready drops while a burst is played out or m_tready holds the output.
// ----------------------------------------------------------------------------
module ldif_attribute_to_pem_stream (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,    // [7:0] data_byte
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [7:0] out_byte, [10:8] phase, [15:11] zero
    output logic [ldif_a2p_pkg::TDATA_W-1:0]    m_tdata,
    output logic                                m_tuser,    // [0] byte_valid
    output logic                                m_tlast,
    input  logic                                i_cfg_we,
    input  logic [ldif_a2p_pkg::REG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ldif_a2p_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);

    ldif_a2p_pkg::t_cfg cfg;
    ldif_a2p_pkg::t_job job;
    logic               accept;
    logic               ready;

    assign accept   = s_tvalid && ready;
    assign s_tready = ready;

    ldif_a2p_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    ldif_a2p_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (s_tdata),
        .i_cfg    (cfg),
        .o_job    (job)
    );

    ldif_a2p_emitter u_emitter (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_job      (job),
        .i_cfg      (cfg),
        .o_ready    (ready),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .o_m_tlast  (m_tlast)
    );

endmodule

/* tb/ldif_a2p_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ldif_a2p_checker
// Follows register writes and accepted LDIF bytes, predicts the PEM text that
// the converter must send and compares every output transaction with it.
// ----------------------------------------------------------------------------
module ldif_a2p_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    input  logic                                i_s_tready,
    input  logic [7:0]                          i_s_tdata,    // [7:0] data_byte
    input  logic                                i_m_tvalid,
    input  logic                                i_m_tready,
    // [7:0] out_byte, [10:8] phase, [15:11] zero
    input  logic [ldif_a2p_pkg::TDATA_W-1:0]    i_m_tdata,
    input  logic                                i_m_tuser,    // [0] byte_valid
    input  logic                                i_m_tlast,
    input  logic                                i_cfg_we,
    input  logic [ldif_a2p_pkg::REG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ldif_a2p_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output int                                  o_pending,
    output int                                  o_fail_count
);
    import ldif_a2p_pkg::*;

    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [7:0] text;
        logic       valid;
        logic       last;
        logic [2:0] phase;
    } t_pem_res;

    logic [CFG_DATA_W-1:0] cfg_regs [NUM_REGS];
    logic [2:0]            conv_phase;
    int                    match_pos;
    int                    out_col;
    int                    fail_count;

    t_pem_res              pem_text_q [$];
    t_pem_res              burst_q [$];
    t_pem_res              want;
    logic [TDATA_W-1:0]    want_tdata;

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        if (c >= 8'h61 && c <= 8'h7A) begin
            return c - 8'h20;
        end
        return c;
    endfunction

    function automatic int attr_length();
        int n;
        n = int'(cfg_regs[REG_NAME_LENGTHS][5:0]);
        if (n == 0) begin
            n = 1;
        end
        if (n > MAX_ATTR_CHARS) begin
            n = MAX_ATTR_CHARS;
        end
        return n;
    endfunction

    function automatic int label_length();
        int n;
        n = int'(cfg_regs[REG_NAME_LENGTHS][12:8]);
        if (n > MAX_LABEL_CHARS) begin
            n = MAX_LABEL_CHARS;
        end
        return n;
    endfunction

    function automatic logic [7:0] attr_char(input int i);
        if (i >= MAX_ATTR_CHARS) begin
            return 8'h00;
        end
        return cfg_regs[i / 8][(i % 8) * 8 +: 8];
    endfunction

    function automatic logic [7:0] label_char(input int i);
        if (i >= MAX_LABEL_CHARS) begin
            return 8'h00;
        end
        return cfg_regs[ATTR_REGS + i / 8][(i % 8) * 8 +: 8];
    endfunction

    task automatic add_char(input logic [7:0] c);
        t_pem_res r;
        r.text  = c;
        r.valid = 1'b1;
        r.last  = 1'b0;
        r.phase = PH_SEARCH;
        burst_q.push_back(r);
    endtask

    // "<prefix><label>-----\n"
    task automatic add_pem_line(input string prefix);
        string tail_txt;
        int    llen;
        tail_txt = "-----\n";
        llen = label_length();
        for (int i = 0; i < prefix.len(); i++) add_char(prefix[i]);
        for (int i = 0; i < llen; i++) add_char(label_char(i));
        for (int i = 0; i < tail_txt.len(); i++) add_char(tail_txt[i]);
    endtask

    task automatic convert_byte(input logic [7:0] b);
        int         alen;
        logic [2:0] shown;
        t_pem_res   r;
        burst_q.delete();
        case (conv_phase)
            PH_SEARCH: begin
                alen = attr_length();
                // a failing byte restarts the match and is not compared again
                if (match_pos >= alen || fold_case(b) == fold_case(attr_char(match_pos))) begin
                    match_pos++;
                end else begin
                    match_pos = 0;
                end
                if (match_pos >= alen) begin
                    match_pos  = 0;
                    conv_phase = PH_DATA;
                    add_pem_line("-----BEGIN ");
                end
            end
            PH_DATA: begin
                if (b == CH_NL) begin
                    conv_phase = PH_LINE_END;
                end else begin
                    add_char(b);
                    out_col++;
                    if (out_col >= LINE_WIDTH) begin
                        out_col = 0;
                        add_char(CH_NL);
                    end
                end
            end
            PH_LINE_END: begin
                if (b == CH_SPACE) begin
                    conv_phase = PH_DATA;
                end else if (b == CH_NL) begin
                    conv_phase = PH_FOOTER;
                end
            end
            PH_FOOTER: begin
                if (out_col != 0) begin
                    add_char(CH_NL);
                end
                out_col = 0;
                add_pem_line("-----END ");
                conv_phase = PH_DONE;
            end
            default: begin
                conv_phase = PH_DONE;
            end
        endcase

        shown = conv_phase;
        if (conv_phase == PH_LINE_END && b != CH_NL && b != CH_SPACE && burst_q.size() == 0) begin
            shown = PH_BAD;
        end
        if (burst_q.size() == 0) begin
            r = '0;
            burst_q.push_back(r);
        end
        for (int k = 0; k < burst_q.size(); k++) begin
            r = burst_q[k];
            r.phase = shown;
            r.last  = (k == burst_q.size() - 1);
            pem_text_q.push_back(r);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) cfg_regs[i] = '0;
            cfg_regs[REG_NAME_LENGTHS] = CFG_DATA_W'(1);
            conv_phase = PH_SEARCH;
            match_pos  = 0;
            out_col    = 0;
            pem_text_q.delete();
        end else begin
            if (i_cfg_we && int'(i_cfg_idx) < NUM_REGS) begin
                if (i_cfg_idx == REG_IDX_W'(REG_NAME_LENGTHS)) begin
                    cfg_regs[i_cfg_idx] = i_cfg_wdata & 64'h1FFF;
                end else begin
                    cfg_regs[i_cfg_idx] = i_cfg_wdata;
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                convert_byte(i_s_tdata);
            end
            if (i_m_tvalid && i_m_tready) begin
                if (pem_text_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS) begin
                        $display("%0t: unexpected output transaction tdata %h tuser %b tlast %b",
                                 $realtime, i_m_tdata, i_m_tuser, i_m_tlast);
                    end
                end else begin
                    want = pem_text_q.pop_front();
                    want_tdata = '0;
                    want_tdata[7:0]  = want.text;
                    want_tdata[10:8] = want.phase;
                    if (i_m_tdata !== want_tdata || i_m_tuser !== want.valid ||
                        i_m_tlast !== want.last) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS) begin
                            $display("%0t: mismatch expected byte %h valid %b last %b phase %0d",
                                     $realtime, want.text, want.valid, want.last, want.phase);
                            $display("%0t:          actual tdata %h tuser %b tlast %b",
                                     $realtime, i_m_tdata, i_m_tuser, i_m_tlast);
                        end
                    end
                end
            end
        end
        o_pending    = pem_text_q.size();
        o_fail_count = fail_count;
    end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the LDIF to PEM converter: sets the attribute name and label, feeds
// search noise and partial matches, tries the length limits, completes a match,
// streams data lines with continuations, stray bytes and a label change, then the footer.
// ----------------------------------------------------------------------------
module tb_top;
    import ldif_a2p_pkg::*;

    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 4;
    localparam int IDLE_SETTLE   = 8;
    localparam int RUN_LIMIT_NS  = 5_000_000;
    localparam int SEARCH_ITEMS  = 110;
    localparam int DATA_ITEMS    = 240;
    localparam int LABEL_SWAP_AT = 180;
    localparam int QUIET_FROM    = 140;
    localparam int QUIET_TO      = 200;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  s_tvalid    = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata     = 8'h00;
    logic                  m_tvalid;
    logic                  m_tready    = 1'b0;
    logic [TDATA_W-1:0]    m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;
    logic                  i_cfg_we    = 1'b0;
    logic [REG_IDX_W-1:0]  i_cfg_idx   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    int                    pending;
    int                    fail_count;
    int                    sent_count  = 0;
    logic                  label_swapped = 1'b0;
    logic [7:0]            key_chars [MAX_ATTR_CHARS];

    // both sides run without idle cycles inside this window
    wire quiet = (sent_count >= QUIET_FROM) && (sent_count < QUIET_TO);

    ldif_attribute_to_pem_stream dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    ldif_a2p_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_m_tlast    (m_tlast),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    always @(negedge i_clk) begin
        m_tready <= quiet || ($urandom_range(0, 99) >= 33);
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("FAILURE");
        $finish;
    end

    function automatic logic [7:0] flip_case(input logic [7:0] c);
        logic [7:0] lc;
        lc = c | 8'h20;
        if (lc >= 8'h61 && lc <= 8'h7A && $urandom_range(0, 1) == 1) begin
            return c ^ 8'h20;
        end
        return c;
    endfunction

    // length fields forced, every other bit random
    function automatic logic [CFG_DATA_W-1:0] lengths_word(input logic [5:0] alen,
                                                         input logic [4:0] llen);
        logic [CFG_DATA_W-1:0] w;
        w = {$urandom, $urandom};
        w[5:0]  = alen;
        w[12:8] = llen;
        return w;
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        @(negedge i_clk);
        if (!quiet && $urandom_range(0, 99) < 33) begin
            s_tvalid <= 1'b0;
            gap = $urandom_range(1, 2);
            repeat (gap) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge i_clk); while (!s_tready);
        sent_count++;
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic drain_and_settle();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (IDLE_SETTLE) @(negedge i_clk);
    endtask

    initial begin
        logic [7:0]            b;
        logic [CFG_DATA_W-1:0] word;
        int                    plen;
        int                    line_len;
        int                    n_bad;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // first character a letter, the rest nonzero so 0x00 always breaks a match
        key_chars[0] = flip_case(8'(8'h41 + $urandom_range(0, 25)));
        for (int i = 1; i < MAX_ATTR_CHARS; i++) key_chars[i] = 8'($urandom_range(1, 255));
        for (int r = 0; r < ATTR_REGS; r++) begin
            for (int j = 0; j < 8; j++) word[j * 8 +: 8] = key_chars[r * 8 + j];
            write_reg(REG_IDX_W'(r), word);
        end
        for (int r = 0; r < LABEL_REGS; r++) begin
            write_reg(REG_IDX_W'(ATTR_REGS + r), {$urandom, $urandom});
        end
        // both lengths above their maximum
        write_reg(REG_IDX_W'(REG_NAME_LENGTHS), lengths_word(6'h3F, 5'h1F));

        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(CH_NL);
        send_byte(CH_SPACE);
        for (int i = 0; i < 5; i++) send_byte(flip_case(key_chars[i]));
        send_byte(8'h00);
        // the byte that breaks the match is not tried against the first character
        send_byte(key_chars[0]);
        send_byte(key_chars[0]);
        send_byte(key_chars[1]);
        send_byte(8'h00);

        while (sent_count < SEARCH_ITEMS) begin
            if ($urandom_range(0, 9) < 7) begin
                plen = $urandom_range(1, 38);
                for (int i = 0; i < plen; i++) send_byte(flip_case(key_chars[i]));
            end
            send_byte(8'($urandom_range(0, 255)));
        end
        send_byte(8'h00);

        // zero attribute length acts as one: digits never match the letter
        drain_and_settle();
        write_reg(REG_IDX_W'(REG_NAME_LENGTHS), lengths_word(6'd0, 5'h1F));
        repeat (3) send_byte(8'(8'h30 + $urandom_range(0, 9)));

        drain_and_settle();
        write_reg(REG_IDX_W'(REG_NAME_LENGTHS), lengths_word(6'(MAX_ATTR_CHARS), 5'h1F));
        for (int i = 0; i < 8; i++) send_byte(flip_case(key_chars[i]));

        // length dropped below the match position: any next byte completes it
        drain_and_settle();
        write_reg(REG_IDX_W'(REG_NAME_LENGTHS), lengths_word(6'd5, 5'h1F));
        send_byte(8'($urandom_range(0, 255)));

        while (sent_count < DATA_ITEMS) begin
            line_len = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 90)
                                                   : $urandom_range(0, 24);
            for (int i = 0; i < line_len; i++) begin
                b = 8'($urandom_range(0, 255));
                send_byte((b == CH_NL) ? 8'h0B : b);
            end
            send_byte(CH_NL);
            // stray bytes after a line end are dropped
            if ($urandom_range(0, 4) == 0) begin
                n_bad = $urandom_range(1, 2);
                for (int i = 0; i < n_bad; i++) begin
                    b = 8'($urandom_range(0, 255));
                    send_byte((b == CH_NL || b == CH_SPACE) ? 8'hA5 : b);
                end
            end
            send_byte(CH_SPACE);
            if (!label_swapped && sent_count >= LABEL_SWAP_AT) begin
                drain_and_settle();
                for (int r = 0; r < LABEL_REGS; r++) begin
                    write_reg(REG_IDX_W'(ATTR_REGS + r), {$urandom, $urandom});
                end
                write_reg(REG_IDX_W'(REG_NAME_LENGTHS),
                          lengths_word(6'($urandom_range(0, 63)), 5'd0));
                label_swapped = 1'b1;
            end
        end

        // blank line, then the byte that brings out the footer
        send_byte(CH_NL);
        send_byte(CH_NL);
        send_byte(8'($urandom_range(0, 255)));
        repeat (5) send_byte(8'($urandom_range(0, 255)));

        drain_and_settle();
        if (fail_count == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
